>>> sv/mbrot_pkg.sv
// Shared types and constants for the Mandelbrot escape-time colour block.
`timescale 1ns / 1ps

package mbrot_pkg;

  // Fixed-point format of the point and of the orbit
  localparam int FRAC_BITS = 28;
  localparam int COORD_W   = 32;
  localparam int COUNT_W   = 8;
  localparam int COL_W     = 8;

  // Orbit registers hold any value reachable in one round from |u| < 2
  localparam int STATE_W   = FRAC_BITS + 5;
  // Multiplier operands only matter while |u| < 2
  localparam int MUL_W     = FRAC_BITS + 2;
  localparam int PROD_W    = 2 * MUL_W;

  // Colour ramp
  localparam int V_W = 11;
  localparam logic [V_W-1:0] RAMP_PERIOD = V_W'(1530);
  localparam logic [V_W-1:0] SEG_1       = V_W'(255);
  localparam logic [V_W-1:0] SEG_2       = V_W'(510);
  localparam logic [V_W-1:0] SEG_3       = V_W'(765);
  localparam logic [V_W-1:0] SEG_4       = V_W'(1020);
  localparam logic [V_W-1:0] SEG_5       = V_W'(1275);
  localparam logic [COL_W-1:0] COL_FULL  = COL_W'(255);

  localparam logic [COUNT_W-1:0] ROUND_LIMIT_RST = COUNT_W'(85);

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RR    = 5'b00010,
    S_II    = 5'b00100,
    S_RI    = 5'b01000,
    S_COLOR = 5'b10000
  } mb_state_t;

endpackage

>>> sv/mandelbrot_escape_time_color.sv
// Mandelbrot escape-time counter with a six-segment RGB colour ramp.
//
//  channel | ports                            | item
//  --------+----------------------------------+---------------------------------------
//  in      | in_tvalid  in_tready  in_tdata   | c_real [31:0], c_imag [63:32]
//  out     | out_tvalid out_tready out_tdata  | escape_count, red, green, blue (8 each)
//  cfg     | cfg_valid  cfg_ready  cfg_data   | round limit [7:0]
//
// One shared signed multiplier forms re*re, im*im and re*im in turn, in states
// S_RR, S_II and S_RI of each round of u = u*u + c. An item takes r rounds, where r
// is the number of rounds tried (at most the round limit), one item at a time.
// rst_n is synchronous, active low; the round limit resets to 85.
// The result waits in an output register; a stalled output only blocks the
// next item once its own result is ready.
`timescale 1ns / 1ps

module mandelbrot_escape_time_color
  import mbrot_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,    // round limit
  // input points
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,    // c_real [31:0], c_imag [63:32]
  // results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata    // escape_count, red, green, blue from bit 0 up
);

  localparam logic signed [STATE_W-1:0] TWO_FIX     = STATE_W'(1) << (FRAC_BITS + 1);
  localparam logic signed [STATE_W-1:0] NEG_TWO_FIX = -TWO_FIX;
  localparam logic [PROD_W:0]           FOUR_SQ     = (PROD_W+1)'(1) << (2*FRAC_BITS + 2);

  mb_state_t                  state_r, state_nxt;
  logic [COUNT_W-1:0]         round_limit_r;
  logic signed [COORD_W-1:0]  cr_r, ci_r;
  logic signed [STATE_W-1:0]  re_r, im_r, re_nxt, im_nxt;
  logic [COUNT_W-1:0]         n_r, count_r;
  logic [PROD_W-1:0]          rr_r, ii_r;
  logic                       out_valid_r;
  logic [31:0]                out_data_r;

  logic signed [MUL_W-1:0]    mul_a, mul_b;
  logic signed [PROD_W-1:0]   mul_p;
  logic                       re_big, im_big, sq_esc, escaped, last_round;
  logic [PROD_W:0]            sq_sum;
  logic                       in_acc, out_free;
  logic signed [STATE_W-1:0]  cr_ext, ci_ext, in_cr_ext, in_ci_ext;
  logic [STATE_W-1:0]         rr_q, ii_q;
  logic [V_W-1:0]             v_raw, v, seg_d;
  logic [COL_W-1:0]           red, green, blue;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // sign extension of the point
  assign cr_ext    = {{(STATE_W-COORD_W){cr_r[COORD_W-1]}}, cr_r};
  assign ci_ext    = {{(STATE_W-COORD_W){ci_r[COORD_W-1]}}, ci_r};
  assign in_cr_ext = {{(STATE_W-COORD_W){in_tdata[COORD_W-1]}}, in_tdata[COORD_W-1:0]};
  assign in_ci_ext = {{(STATE_W-COORD_W){in_tdata[2*COORD_W-1]}},
                      in_tdata[2*COORD_W-1:COORD_W]};

  // shared multiplier operand select
  always_comb begin
    unique case (state_r)
      S_RR: begin
        mul_a = re_r[MUL_W-1:0];
        mul_b = re_r[MUL_W-1:0];
      end
      S_II: begin
        mul_a = im_r[MUL_W-1:0];
        mul_b = im_r[MUL_W-1:0];
      end
      default: begin
        mul_a = re_r[MUL_W-1:0];
        mul_b = im_r[MUL_W-1:0];
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // escape test: a component at or beyond 2 escapes; else exact |u|^2 >= 4
  assign re_big     = (re_r >= TWO_FIX) || (re_r <= NEG_TWO_FIX);
  assign im_big     = (im_r >= TWO_FIX) || (im_r <= NEG_TWO_FIX);
  assign sq_sum     = {1'b0, rr_r} + {1'b0, ii_r};
  assign sq_esc     = (sq_sum >= FOUR_SQ);
  assign escaped    = re_big || im_big || sq_esc;
  assign last_round = (n_r == (round_limit_r - COUNT_W'(1)));

  // next orbit point, products floored to FRAC_BITS fraction bits
  assign rr_q   = {{(STATE_W-(PROD_W-FRAC_BITS)){1'b0}}, rr_r[PROD_W-1:FRAC_BITS]};
  assign ii_q   = {{(STATE_W-(PROD_W-FRAC_BITS)){1'b0}}, ii_r[PROD_W-1:FRAC_BITS]};
  assign re_nxt = $signed(rr_q - ii_q) + cr_ext;
  // 2*re*im / 2^F is the product taken from bit F-1 up
  assign im_nxt = $signed(mul_p[PROD_W-1:FRAC_BITS-1]) + ci_ext;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) state_nxt = (round_limit_r == '0) ? S_COLOR : S_RR;
      S_RR:    state_nxt = S_II;
      S_II:    state_nxt = S_RI;
      S_RI:    state_nxt = (escaped || last_round) ? S_COLOR : S_RR;
      S_COLOR: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      round_limit_r <= ROUND_LIMIT_RST;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) round_limit_r <= cfg_data;
    end
  end

  // orbit datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cr_r    <= in_tdata[COORD_W-1:0];
          ci_r    <= in_tdata[2*COORD_W-1:COORD_W];
          // first round from u = 0 gives u = c exactly
          re_r    <= in_cr_ext;
          im_r    <= in_ci_ext;
          n_r     <= '0;
          count_r <= '0;
        end
      end
      S_RR: rr_r <= mul_p;
      S_II: ii_r <= mul_p;
      S_RI: begin
        if (escaped) begin
          count_r <= n_r;
        end else if (last_round) begin
          count_r <= '0;
        end else begin
          re_r <= re_nxt;
          im_r <= im_nxt;
          n_r  <= n_r + COUNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // colour ramp from v = 5*count mod 1530
  always_comb begin
    v_raw = {{(V_W-COUNT_W-2){1'b0}}, count_r, 2'b00}
          + {{(V_W-COUNT_W){1'b0}}, count_r};
    v     = (v_raw >= RAMP_PERIOD) ? (v_raw - RAMP_PERIOD) : v_raw;
    seg_d = '0;
    red   = '0;
    green = '0;
    blue  = '0;
    if (v < SEG_1) begin
      red = v[COL_W-1:0];
    end else if (v <= SEG_2) begin
      seg_d = v - SEG_1;
      red   = COL_FULL;
      green = seg_d[COL_W-1:0];
    end else if (v <= SEG_3) begin
      seg_d = SEG_3 - v;
      red   = seg_d[COL_W-1:0];
      green = COL_FULL;
    end else if (v <= SEG_4) begin
      seg_d = v - SEG_3;
      green = COL_FULL;
      blue  = seg_d[COL_W-1:0];
    end else if (v <= SEG_5) begin
      seg_d = SEG_5 - v;
      green = seg_d[COL_W-1:0];
      blue  = COL_FULL;
    end else begin
      seg_d = v - SEG_5;
      red   = seg_d[COL_W-1:0];
      blue  = COL_FULL;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_COLOR) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_COLOR) && out_free) begin
      out_data_r <= {blue, green, red, count_r};
    end
  end

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the Mandelbrot escape-time colour block.
`timescale 1ns / 1ps

module testbench
  import mbrot_pkg::*;
();

  // One result item as it sits on out_tdata, lowest field last
  typedef struct packed {
    logic [COL_W-1:0]   blue;
    logic [COL_W-1:0]   green;
    logic [COL_W-1:0]   red;
    logic [COUNT_W-1:0] count;
  } pixel_t;

  // Predicts the pixel of every accepted point and checks results in order
  class pixel_scoreboard;
    pixel_t expected_pixels[$];
    int     iter_limit;
    int     errors;
    int     points;
    int     checked;
    int     deepest;

    function new();
      iter_limit = int'(ROUND_LIMIT_RST);
      errors     = 0;
      points     = 0;
      checked    = 0;
      deepest    = 0;
    endfunction

    function void set_round_limit(logic [COUNT_W-1:0] value);
      iter_limit = int'(value);
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    // Round in which u = u*u + c first leaves the radius-2 disc, 0 if never
    function logic [COUNT_W-1:0] escape_round(logic [COORD_W-1:0] cr, logic [COORD_W-1:0] ci);
      longint re, im, nre, nim, two, four_sq;
      re      = 0;
      im      = 0;
      two     = longint'(1) <<< (FRAC_BITS + 1);
      four_sq = longint'(1) <<< (2 * FRAC_BITS + 2);
      for (int n = 0; n < iter_limit; n++) begin
        // |re|, |im| < 2 here, so every product fits in 64 bits
        nre = ((re * re) >>> FRAC_BITS) - ((im * im) >>> FRAC_BITS)
              + longint'($signed(cr));
        nim = ((2 * re * im) >>> FRAC_BITS) + longint'($signed(ci));
        re  = nre;
        im  = nim;
        if (re >= two || re <= -two || im >= two || im <= -two)
          return COUNT_W'(n);
        if (re * re + im * im >= four_sq)
          return COUNT_W'(n);
      end
      return '0;
    endfunction

    // Six-segment ramp black-red-yellow-green-cyan-blue-magenta
    function pixel_t paint(logic [COUNT_W-1:0] count);
      int     v;
      pixel_t px;
      v        = (5 * int'(count)) % int'(RAMP_PERIOD);
      px       = '0;
      px.count = count;
      if (v < int'(SEG_1)) begin
        px.red = COL_W'(v);
      end else if (v <= int'(SEG_2)) begin
        px.red   = COL_FULL;
        px.green = COL_W'(v - int'(SEG_1));
      end else if (v <= int'(SEG_3)) begin
        px.red   = COL_W'(int'(SEG_3) - v);
        px.green = COL_FULL;
      end else if (v <= int'(SEG_4)) begin
        px.green = COL_FULL;
        px.blue  = COL_W'(v - int'(SEG_3));
      end else if (v <= int'(SEG_5)) begin
        px.green = COL_W'(int'(SEG_5) - v);
        px.blue  = COL_FULL;
      end else begin
        px.red  = COL_W'(v - int'(SEG_5));
        px.blue = COL_FULL;
      end
      return px;
    endfunction

    function void note_point(logic [COORD_W-1:0] cr, logic [COORD_W-1:0] ci);
      expected_pixels.push_back(paint(escape_round(cr, ci)));
      points++;
    endfunction

    function void report(string field, logic [COL_W-1:0] want, logic [COL_W-1:0] got);
      if (errors < 200)
        $error("%s: expected %0d, got %0d", field, want, got);
      errors++;
    endfunction

    function void check_pixel(logic [31:0] data);
      pixel_t got, want;
      got = pixel_t'(data);
      if (expected_pixels.size() == 0) begin
        if (errors < 200)
          $error("result item 0x%08h arrived with no point outstanding", data);
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      checked++;
      if (int'(got.count) > deepest)
        deepest = int'(got.count);
      if (got.count != want.count) report("escape_count", want.count, got.count);
      if (got.red != want.red)     report("red", want.red, got.red);
      if (got.green != want.green) report("green", want.green, got.green);
      if (got.blue != want.blue)   report("blue", want.blue, got.blue);
    endfunction
  endclass

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data  = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata  = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;

  pixel_scoreboard sb;
  int sender_idle_pct = 0;
  int stall_pct       = 0;
  int receiver_hold   = 0;
  int settings_used   = 0;

  // Corner points: origin, exact radius-2 hits, field extremes, the cusp,
  // periodic orbits, slow escapes and odd LSBs for negative-product flooring
  logic [31:0] corner_re[20] = '{
    32'h0000_0000, 32'h2000_0000, 32'hE000_0000, 32'h0000_0000, 32'h0000_0000,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0400_0000,
    32'h0428_F5C3, 32'hF000_0000, 32'h0000_0000, 32'h0000_0000, 32'hF400_0000,
    32'h1FFF_FFFF, 32'h1800_0000, 32'h1000_0000, 32'hF800_0001, 32'h0000_0001
  };
  logic [31:0] corner_im[20] = '{
    32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h2000_0000, 32'hE000_0000,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
    32'h0000_0000, 32'h0000_0000, 32'h1000_0000, 32'hF000_0000, 32'h0199_999A,
    32'h0000_0000, 32'h1800_0000, 32'h1000_0000, 32'h0800_0003, 32'hFFFF_FFFF
  };

  mandelbrot_escape_time_color dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: check accepted items, then pick next cycle's tready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_pixel(out_tdata);
    if (receiver_hold > 0) begin
      out_tready <= 1'b0;
      receiver_hold--;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic wait_drained();
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_round_limit(input logic [7:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_round_limit(value);
    settings_used++;
  endtask

  // Offer one point, idling first at the sender's rate
  task automatic send_point(input logic [31:0] cr, input logic [31:0] ci);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
    end
    in_tdata  <= {ci, cr};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_point(cr, ci);
  endtask

  // Mostly points around the set, where orbits run long; some noise
  task automatic random_point(output logic [31:0] cr, output logic [31:0] ci);
    case ($urandom_range(0, 9))
      0: begin
        cr = $urandom;
        ci = $urandom;
      end
      1: begin
        cr = $urandom_range(0, 32'h7FFF_FFFF) - 32'h4000_0000;
        ci = $urandom_range(0, 32'h7FFF_FFFF) - 32'h4000_0000;
      end
      default: begin
        // re in [-2, 0.5], im in [-1.25, 1.25]
        cr = $urandom_range(0, 32'h2800_0000) - 32'h2000_0000;
        ci = $urandom_range(0, 32'h2800_0000) - 32'h1400_0000;
      end
    endcase
  endtask

  task automatic run_phase(input logic [7:0] limit, input int count, input int send_pct,
                           input int stall, input int hold_at, input int pause_at);
    logic [31:0] cr, ci;
    wait_drained();
    sender_idle_pct = send_pct;
    stall_pct       = stall;
    write_round_limit(limit);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at)
        receiver_hold = 500;
      if (i == pause_at) begin
        in_tvalid <= 1'b0;
        wait_drained();
      end
      random_point(cr, ci);
      send_point(cr, ci);
    end
    in_tvalid <= 1'b0;
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Corner points under the reset round limit
    for (int i = 0; i < 20; i++)
      send_point(corner_re[i], corner_im[i]);
    in_tvalid <= 1'b0;

    run_phase(8'd255, 60, 0, 0, -1, -1);
    run_phase(8'd1, 200, 46, 0, 40, -1);
    run_phase(8'd0, 30, 0, 46, -1, -1);
    run_phase(8'd20, 300, 33, 33, -1, 150);
    run_phase(8'd100, 250, 0, 46, -1, -1);
    run_phase(8'($urandom_range(2, 254)), 60, 0, 0, -1, -1);
    run_phase(8'($urandom_range(2, 254)), 60, 46, 0, -1, -1);
    run_phase(8'($urandom_range(2, 254)), 60, 0, 46, -1, -1);
    run_phase(8'($urandom_range(2, 254)), 60, 33, 33, -1, -1);

    wait_drained();
    repeat (800) @(posedge clk);

    $display("Covered %0d points and %0d pixels over %0d round-limit settings,",
             sb.points, sb.checked, settings_used + 1);
    $display("with escape counts up to %0d and both sides idling and stalling.", sb.deepest);
    if (sb.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Run limit, several times the slowest correct run
  initial begin
    #40_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
